FILE: src/crgm_pkg.sv
// Shared types, constants and arithmetic helpers for the cross-ratio gaze mapper.
// Used by crgm_div and cross_ratio_gaze_mapper; depends on nothing.
package crgm_pkg;

  typedef logic signed [31:0] val_t;
  typedef logic signed [63:0] wide_t;

  typedef struct packed {
    val_t x;
    val_t y;
  } pt_t;

  typedef struct packed {
    pt_t p1;
    pt_t p2;
    pt_t q1;
    pt_t q2;
  } lines_t;

  typedef struct packed {
    wide_t den_a;
    wide_t den_b;
    wide_t n1_a;
    wide_t n1_b;
    wide_t n2_a;
    wide_t n2_b;
  } xprod_t;

  typedef struct packed {
    wide_t den;
    wide_t n1;
    wide_t n2;
  } xcrs_t;

  typedef struct packed {
    wide_t a;
    wide_t b;
  } pair_t;

  typedef struct packed {
    wide_t ax;
    wide_t bx;
    wide_t ay;
    wide_t by;
  } tprod_t;

  localparam val_t VLIM = 32'sh7fff_ffff;
  localparam wide_t VLIM_W = 64'sd2147483647;

  localparam int DIV_STEPS = 31;
  localparam int DIV_LAT = DIV_STEPS + 2;

  localparam int IDX_W = 8;
  localparam logic [IDX_W-1:0] REG_ALPHA_TL = 8'd0;
  localparam logic [IDX_W-1:0] REG_ALPHA_TR = 8'd1;
  localparam logic [IDX_W-1:0] REG_ALPHA_BL = 8'd2;
  localparam logic [IDX_W-1:0] REG_ALPHA_BR = 8'd3;
  localparam logic [15:0] ALPHA_RESET = 16'd8192;

  // floor(x/3) = (x*K3)>>24, exact for x < 2^23
  localparam int DIV3_SH = 24;
  localparam logic [23:0] DIV3_K = 24'd5592406;
  // floor(x/5) = (x*K5)>>28, exact for x < 2^26
  localparam int DIV5_SH = 28;
  localparam logic [26:0] DIV5_K = 27'd53687092;
  localparam logic [5:0] EXTRA_NUM = 6'd41;

  function automatic val_t sat32(input wide_t v);
    if (v > VLIM_W) begin
      return VLIM;
    end else if (v < -VLIM_W) begin
      return -VLIM;
    end
    return val_t'(v[31:0]);
  endfunction

  function automatic logic signed [15:0] sat16(input wide_t v);
    if (v > 64'sd32767) begin
      return 16'sh7fff;
    end else if (v < -64'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic pt_t psub(input pt_t a, input pt_t b);
    pt_t r;
    r.x = sat32(wide_t'(a.x) - wide_t'(b.x));
    r.y = sat32(wide_t'(a.y) - wide_t'(b.y));
    return r;
  endfunction

  function automatic wide_t mul(input val_t a, input val_t b);
    return wide_t'(a) * wide_t'(b);
  endfunction

  // truncating (toward zero) division by 2^sh
  function automatic wide_t tz_shift(input wide_t v, input int sh);
    wide_t m;
    m = -v;
    return v[63] ? -(m >>> sh) : (v >>> sh);
  endfunction

  function automatic xprod_t xmul(input lines_t l);
    xprod_t r;
    r.den_a = mul(l.p2.x, l.q2.y);
    r.den_b = mul(l.p2.y, l.q2.x);
    r.n1_a  = mul(l.q1.x, l.q2.y);
    r.n1_b  = mul(l.q1.y, l.q2.x);
    r.n2_a  = mul(l.p1.x, l.p2.y);
    r.n2_b  = mul(l.p1.y, l.p2.x);
    return r;
  endfunction

  function automatic xcrs_t xcrs(input xprod_t p);
    xcrs_t r;
    r.den = p.den_a - p.den_b;
    r.n1  = p.n1_a - p.n1_b;
    r.n2  = p.n2_a - p.n2_b;
    return r;
  endfunction

  function automatic pair_t cmul(input pt_t a, input pt_t b);
    pair_t r;
    r.a = mul(a.x, b.y);
    r.b = mul(a.y, b.x);
    return r;
  endfunction

endpackage

FILE: src/crgm_div.sv
// Pipelined restoring divider: q = sat(trunc(n * 2^FB / d)) to +-(2^31-1).
// One quotient bit per stage, DIV_LAT register stages; uses crgm_pkg.
module crgm_div #(
  parameter int FB = 8
) (
  input  logic           clk,
  input  logic           en,
  input  crgm_pkg::wide_t n,
  input  crgm_pkg::wide_t d,
  output crgm_pkg::val_t  q
);
  import crgm_pkg::*;

  localparam int RW = 64 + DIV_STEPS + 1;

  logic [RW-1:0]        rem [DIV_STEPS+1];
  logic [63:0]          den [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo [DIV_STEPS+1];
  logic                 neg [DIV_STEPS+1];
  logic                 ovf [DIV_STEPS+1];

  logic [63:0]          un;
  logic [63:0]          ud;
  logic [DIV_STEPS-1:0] qmag;

  assign un = n[63] ? (~n + 64'd1) : n;
  assign ud = d[63] ? (~d + 64'd1) : d;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(un) << FB;
      den[0] <= ud;
      quo[0] <= '0;
      neg[0] <= n[63] ^ d[63];
      ovf[0] <= (RW'(un) << FB) >= (RW'(ud) << DIV_STEPS);
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [RW-1:0] sub;
    assign sub = RW'(den[k]) << (DIV_STEPS - 1 - k);
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k] >= sub) begin
          rem[k+1] <= rem[k] - sub;
          quo[k+1] <= {quo[k][DIV_STEPS-2:0], 1'b1};
        end else begin
          rem[k+1] <= rem[k];
          quo[k+1] <= {quo[k][DIV_STEPS-2:0], 1'b0};
        end
        den[k+1] <= den[k];
        neg[k+1] <= neg[k];
        ovf[k+1] <= ovf[k];
      end
    end
  end

  assign qmag = ovf[DIV_STEPS] ? '1 : quo[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      q <= neg[DIV_STEPS] ? -val_t'({1'b0, qmag}) : val_t'({1'b0, qmag});
    end
  end

endmodule

FILE: src/cross_ratio_gaze_mapper.sv
// Cross-ratio gaze mapper top level: eye observation in, screen point out.
// Uses crgm_pkg and crgm_div.
//
// Takes one observation per clock while in_stall is low and returns one screen
// point per observation, in order. The pipeline is built from four chained
// 33-stage divider pipelines (line crossings, second crossings, cross ratios,
// final normalization) plus 23 stages of multiply and add. The whole pipeline
// advances unless a finished point is held by out_stall; in_stall follows it.
// Alpha gains are written through the cfg port (always ready) and must only be
// changed while no item is in flight.
module cross_ratio_gaze_mapper #(
  parameter int COORD_WIDTH   = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [crgm_pkg::IDX_W-1:0]  cfg_index,
  input  logic [15:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [31:0]                 pupil_point,
  input  logic [31:0]                 glint_point,
  input  logic [31:0]                 top_left_point,
  input  logic [31:0]                 top_right_point,
  input  logic [31:0]                 bottom_left_point,
  input  logic [31:0]                 bottom_right_point,
  input  logic                        bottom_right_found,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [15:0]          screen_x,
  output logic signed [15:0]          screen_y,
  output logic                        degenerate
);
  import crgm_pkg::*;

  localparam int CW_EFF = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
  localparam int NSTG = 23 + 4 * DIV_LAT;

  typedef struct packed {
    pt_t       pupil;
    pt_t       glint;
    pt_t [3:0] c;
    logic      found;
  } item_t;

  typedef struct packed {
    pt_t [3:0] tr;
    pt_t       pupil;
    pt_t [2:0] p2;
    pt_t [2:0] q2;
    logic      bad;
  } c1_t;

  typedef struct packed {
    pt_t [2:0] tr;
    pt_t [3:0] p2;
    pt_t [3:0] q2;
    logic      bad;
  } c2_t;

  function automatic val_t dec(input logic [15:0] h);
    logic signed [CW_EFF-1:0] s;
    s = h[CW_EFF-1:0];
    return val_t'(s) <<< 4;
  endfunction

  function automatic pt_t unpack(input logic [31:0] f);
    pt_t p;
    p.x = dec(f[31:16]);
    p.y = dec(f[15:0]);
    return p;
  endfunction

  logic            en;
  logic [NSTG-1:0] vld;
  logic [15:0]     alpha [4];

  assign en        = !(vld[NSTG-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[NSTG-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        alpha[i] <= ALPHA_RESET;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ALPHA_TL: alpha[0] <= cfg_data;
        REG_ALPHA_TR: alpha[1] <= cfg_data;
        REG_ALPHA_BL: alpha[2] <= cfg_data;
        REG_ALPHA_BR: alpha[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- input decode and bottom-right extrapolation
  item_t       a_it, b_it, c_it, d_it, e_it, f_it, f_next;
  logic [22:0] b_sx, b_sy;
  logic        b_nx, b_ny;
  pt_t         c_m, d_m, e_m;
  logic [28:0] d_tx, d_ty;
  logic        d_nx, d_ny, e_nx, e_ny;
  logic [24:0] e_qx, e_qy;

  val_t        sum_x, sum_y, abs_sx, abs_sy;
  logic [46:0] m_px, m_py;
  val_t        m_x, m_y, dif_x, dif_y, adf_x, adf_y;
  logic [52:0] q_px, q_py;
  val_t        qv_x, qv_y;

  always_comb begin
    sum_x  = a_it.c[0].x + a_it.c[1].x + a_it.c[2].x;
    sum_y  = a_it.c[0].y + a_it.c[1].y + a_it.c[2].y;
    abs_sx = sum_x[31] ? -sum_x : sum_x;
    abs_sy = sum_y[31] ? -sum_y : sum_y;
    m_px   = b_sx * DIV3_K;
    m_py   = b_sy * DIV3_K;
    m_x    = val_t'(m_px[DIV3_SH +: 23]);
    m_y    = val_t'(m_py[DIV3_SH +: 23]);
    dif_x  = c_m.x - c_it.c[0].x;
    dif_y  = c_m.y - c_it.c[0].y;
    adf_x  = dif_x[31] ? -dif_x : dif_x;
    adf_y  = dif_y[31] ? -dif_y : dif_y;
    q_px   = d_tx[28:3] * DIV5_K;
    q_py   = d_ty[28:3] * DIV5_K;
    qv_x   = val_t'(e_qx);
    qv_y   = val_t'(e_qy);
  end

  always_comb begin
    f_next = e_it;
    if (!e_it.found) begin
      f_next.c[3].x = sat32(wide_t'(e_m.x) + wide_t'(e_nx ? -qv_x : qv_x));
      f_next.c[3].y = sat32(wide_t'(e_m.y) + wide_t'(e_ny ? -qv_y : qv_y));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_it.pupil <= unpack(pupil_point);
      a_it.glint <= unpack(glint_point);
      a_it.c[0]  <= unpack(top_left_point);
      a_it.c[1]  <= unpack(top_right_point);
      a_it.c[2]  <= unpack(bottom_left_point);
      a_it.c[3]  <= unpack(bottom_right_point);
      a_it.found <= bottom_right_found;

      b_it <= a_it;
      b_sx <= abs_sx[22:0];
      b_sy <= abs_sy[22:0];
      b_nx <= sum_x[31];
      b_ny <= sum_y[31];

      c_it  <= b_it;
      c_m.x <= b_nx ? -m_x : m_x;
      c_m.y <= b_ny ? -m_y : m_y;

      d_it <= c_it;
      d_m  <= c_m;
      d_tx <= adf_x[22:0] * EXTRA_NUM;
      d_ty <= adf_y[22:0] * EXTRA_NUM;
      d_nx <= dif_x[31];
      d_ny <= dif_y[31];

      e_it <= d_it;
      e_m  <= d_m;
      e_qx <= q_px[DIV5_SH +: 25];
      e_qy <= q_py[DIV5_SH +: 25];
      e_nx <= d_nx;
      e_ny <= d_ny;

      f_it <= f_next;
    end
  end

  // ---------------- corner scaling about the glint
  wide_t     g_px [4];
  wide_t     g_py [4];
  pt_t       g_glint, g_pupil, h_pupil;
  pt_t [3:0] h_tr;

  for (genvar i = 0; i < 4; i++) begin : g_premap
    pt_t gd;
    assign gd = psub(f_it.c[i], f_it.glint);
    always_ff @(posedge clk) begin
      if (en) begin
        g_px[i]   <= mul(gd.x, val_t'({16'b0, alpha[i]}));
        g_py[i]   <= mul(gd.y, val_t'({16'b0, alpha[i]}));
        h_tr[i].x <= sat32(wide_t'(g_glint.x) + tz_shift(g_px[i], 12));
        h_tr[i].y <= sat32(wide_t'(g_glint.y) + tz_shift(g_py[i], 12));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_glint <= f_it.glint;
      g_pupil <= f_it.pupil;
      h_pupil <= g_pupil;
    end
  end

  // ---------------- first crossings: vertical, horizontal vanishing points, center
  lines_t    i_ln [3];
  pt_t [3:0] i_tr, j_tr;
  pt_t       i_pupil, j_pupil;
  xprod_t    j_xp [3];
  pt_t [2:0] j_p2, j_q2;
  xcrs_t     k_cr [3];
  c1_t       k_c1;
  c1_t       dl1 [DIV_LAT];
  val_t      t1a [3];
  val_t      t2a [3];
  tprod_t    m_pr [3];
  c1_t       m_c1;
  pt_t [2:0] n_pt;
  pt_t [3:0] n_tr;
  pt_t       n_pupil;
  logic      n_bad;

  always_ff @(posedge clk) begin
    if (en) begin
      i_ln[0] <= '{p1: h_tr[0], p2: psub(h_tr[2], h_tr[0]),
                   q1: h_tr[1], q2: psub(h_tr[3], h_tr[1])};
      i_ln[1] <= '{p1: h_tr[0], p2: psub(h_tr[1], h_tr[0]),
                   q1: h_tr[2], q2: psub(h_tr[3], h_tr[2])};
      i_ln[2] <= '{p1: h_tr[0], p2: psub(h_tr[3], h_tr[0]),
                   q1: h_tr[1], q2: psub(h_tr[2], h_tr[1])};
      i_tr    <= h_tr;
      i_pupil <= h_pupil;
      j_tr    <= i_tr;
      j_pupil <= i_pupil;
      k_c1.tr    <= j_tr;
      k_c1.pupil <= j_pupil;
      k_c1.p2    <= j_p2;
      k_c1.q2    <= j_q2;
      k_c1.bad   <= (j_xp[0].den_a == j_xp[0].den_b) || (j_xp[1].den_a == j_xp[1].den_b)
                    || (j_xp[2].den_a == j_xp[2].den_b);
      dl1[0] <= k_c1;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl1[i] <= dl1[i-1];
      end
      m_c1    <= dl1[DIV_LAT-1];
      n_tr    <= m_c1.tr;
      n_pupil <= m_c1.pupil;
      n_bad   <= m_c1.bad;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_x1
    always_ff @(posedge clk) begin
      if (en) begin
        j_xp[k] <= xmul(i_ln[k]);
        j_p2[k] <= i_ln[k].p2;
        j_q2[k] <= i_ln[k].q2;
        k_cr[k] <= xcrs(j_xp[k]);
        m_pr[k].ax <= mul(dl1[DIV_LAT-1].p2[k].x, t1a[k]);
        m_pr[k].bx <= mul(dl1[DIV_LAT-1].q2[k].x, t2a[k]);
        m_pr[k].ay <= mul(dl1[DIV_LAT-1].p2[k].y, t1a[k]);
        m_pr[k].by <= mul(dl1[DIV_LAT-1].q2[k].y, t2a[k]);
        n_pt[k].x  <= sat32(tz_shift(m_pr[k].ax - m_pr[k].bx, 8));
        n_pt[k].y  <= sat32(tz_shift(m_pr[k].ay - m_pr[k].by, 8));
      end
    end
    crgm_div #(.FB(8)) u_t1 (.clk(clk), .en(en), .n(k_cr[k].n1), .d(k_cr[k].den), .q(t1a[k]));
    crgm_div #(.FB(8)) u_t2 (.clk(clk), .en(en), .n(k_cr[k].n2), .d(k_cr[k].den), .q(t2a[k]));
  end

  // ---------------- second crossings on the top and left edges
  lines_t    i2_ln [4];
  pt_t [2:0] i2_tr, j2_tr;
  logic      i2_bad, j2_bad;
  xprod_t    j2_xp [4];
  pt_t [3:0] j2_p2, j2_q2;
  xcrs_t     k2_cr [4];
  c2_t       k2_c2;
  c2_t       dl2 [DIV_LAT];
  val_t      t1b [4];
  val_t      t2b [4];
  tprod_t    m2_pr [4];
  c2_t       m2_c2;
  pt_t [3:0] u;
  pt_t [2:0] u_tr;
  logic      u_bad;

  always_ff @(posedge clk) begin
    if (en) begin
      i2_ln[0] <= '{p1: n_pt[0], p2: psub(n_pt[0], n_pt[2]),
                    q1: n_tr[0], q2: psub(n_tr[1], n_tr[0])};
      i2_ln[1] <= '{p1: n_pt[0], p2: psub(n_pt[0], n_pupil),
                    q1: n_tr[0], q2: psub(n_tr[1], n_tr[0])};
      i2_ln[2] <= '{p1: n_pt[1], p2: psub(n_pt[1], n_pupil),
                    q1: n_tr[0], q2: psub(n_tr[2], n_tr[0])};
      i2_ln[3] <= '{p1: n_pt[1], p2: psub(n_pt[1], n_pt[2]),
                    q1: n_tr[0], q2: psub(n_tr[2], n_tr[0])};
      i2_tr  <= n_tr[2:0];
      i2_bad <= n_bad;
      j2_tr  <= i2_tr;
      j2_bad <= i2_bad;
      k2_c2.tr  <= j2_tr;
      k2_c2.p2  <= j2_p2;
      k2_c2.q2  <= j2_q2;
      k2_c2.bad <= j2_bad || (j2_xp[0].den_a == j2_xp[0].den_b)
                   || (j2_xp[1].den_a == j2_xp[1].den_b)
                   || (j2_xp[2].den_a == j2_xp[2].den_b)
                   || (j2_xp[3].den_a == j2_xp[3].den_b);
      dl2[0] <= k2_c2;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl2[i] <= dl2[i-1];
      end
      m2_c2 <= dl2[DIV_LAT-1];
      u_tr  <= m2_c2.tr;
      u_bad <= m2_c2.bad;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_x2
    always_ff @(posedge clk) begin
      if (en) begin
        j2_xp[k] <= xmul(i2_ln[k]);
        j2_p2[k] <= i2_ln[k].p2;
        j2_q2[k] <= i2_ln[k].q2;
        k2_cr[k] <= xcrs(j2_xp[k]);
        m2_pr[k].ax <= mul(dl2[DIV_LAT-1].p2[k].x, t1b[k]);
        m2_pr[k].bx <= mul(dl2[DIV_LAT-1].q2[k].x, t2b[k]);
        m2_pr[k].ay <= mul(dl2[DIV_LAT-1].p2[k].y, t1b[k]);
        m2_pr[k].by <= mul(dl2[DIV_LAT-1].q2[k].y, t2b[k]);
        u[k].x <= sat32(tz_shift(m2_pr[k].ax - m2_pr[k].bx, 8));
        u[k].y <= sat32(tz_shift(m2_pr[k].ay - m2_pr[k].by, 8));
      end
    end
    crgm_div #(.FB(8)) u_t1 (.clk(clk), .en(en), .n(k2_cr[k].n1), .d(k2_cr[k].den), .q(t1b[k]));
    crgm_div #(.FB(8)) u_t2 (.clk(clk), .en(en), .n(k2_cr[k].n2), .d(k2_cr[k].den), .q(t2b[k]));
  end

  // ---------------- cross ratios and final normalization
  pair_t r1_p [8];
  logic  r1_bad;
  wide_t r2_c [8];
  logic  r2_bad;
  logic  dl3 [DIV_LAT];
  val_t  rq [4];
  wide_t p1_x, p1_y;
  logic  p1_bad;
  val_t  crx, cry;
  wide_t dxv, dyv;
  logic  p2_bad;
  logic  dl4 [DIV_LAT];
  val_t  ox, oy;

  always_ff @(posedge clk) begin
    if (en) begin
      r1_p[0] <= cmul(u_tr[1], u[0]);
      r1_p[1] <= cmul(u[1], u_tr[0]);
      r1_p[2] <= cmul(u_tr[1], u[1]);
      r1_p[3] <= cmul(u[0], u_tr[0]);
      r1_p[4] <= cmul(u_tr[0], u[2]);
      r1_p[5] <= cmul(u[3], u_tr[2]);
      r1_p[6] <= cmul(u_tr[0], u[3]);
      r1_p[7] <= cmul(u[2], u_tr[2]);
      r1_bad  <= u_bad;
      for (int i = 0; i < 8; i++) begin
        r2_c[i] <= r1_p[i].a - r1_p[i].b;
      end
      r2_bad <= r1_bad || (r1_p[2].a == r1_p[2].b) || (r1_p[3].a == r1_p[3].b)
                || (r1_p[6].a == r1_p[6].b) || (r1_p[7].a == r1_p[7].b);
      dl3[0] <= r2_bad;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl3[i] <= dl3[i-1];
      end
      p1_x   <= mul(rq[0], rq[1]);
      p1_y   <= mul(rq[2], rq[3]);
      p1_bad <= dl3[DIV_LAT-1];
      crx    <= sat32(tz_shift(p1_x, 16));
      cry    <= sat32(tz_shift(p1_y, 16));
      dxv    <= wide_t'(sat32(tz_shift(p1_x, 16))) + 64'sd65536;
      dyv    <= wide_t'(sat32(tz_shift(p1_y, 16))) + 64'sd65536;
      p2_bad <= p1_bad || (tz_shift(p1_x, 16) == -64'sd65536)
                || (tz_shift(p1_y, 16) == -64'sd65536);
      dl4[0] <= p2_bad;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl4[i] <= dl4[i-1];
      end
      degenerate <= dl4[DIV_LAT-1];
      screen_x   <= dl4[DIV_LAT-1] ? 16'sd0
                    : sat16((64'sd1 <<< OUT_FRAC_BITS) - wide_t'(ox));
      screen_y   <= dl4[DIV_LAT-1] ? 16'sd0 : sat16(wide_t'(oy));
    end
  end

  crgm_div #(.FB(16)) u_rax (.clk(clk), .en(en), .n(r2_c[0]), .d(r2_c[2]), .q(rq[0]));
  crgm_div #(.FB(16)) u_rbx (.clk(clk), .en(en), .n(r2_c[1]), .d(r2_c[3]), .q(rq[1]));
  crgm_div #(.FB(16)) u_ray (.clk(clk), .en(en), .n(r2_c[4]), .d(r2_c[6]), .q(rq[2]));
  crgm_div #(.FB(16)) u_rby (.clk(clk), .en(en), .n(r2_c[5]), .d(r2_c[7]), .q(rq[3]));

  crgm_div #(.FB(OUT_FRAC_BITS)) u_ox (
    .clk(clk), .en(en), .n(wide_t'(crx)), .d(dxv), .q(ox)
  );
  crgm_div #(.FB(OUT_FRAC_BITS)) u_oy (
    .clk(clk), .en(en), .n(wide_t'(cry)), .d(dyv), .q(oy)
  );

endmodule

FILE: verif/cross_ratio_gaze_mapper_tb.sv
// Self-checking testbench for cross_ratio_gaze_mapper: drives eye observations and
// alpha writes, and predicts each screen point with an in-bench fixed-point model.
// Depends on crgm_pkg and the cross_ratio_gaze_mapper RTL.

typedef struct {
  longint x;
  longint y;
} gaze_vec_t;

typedef struct {
  logic signed [15:0] sx;
  logic signed [15:0] sy;
  logic               degen;
} screen_pt_t;

class gaze_scoreboard;
  localparam longint LIM31 = 64'sd2147483647;

  longint unsigned alpha[4];
  bit flawed;
  screen_pt_t pending[$];
  int errors;
  int points;
  int degens;

  function new();
    foreach (alpha[i]) alpha[i] = crgm_pkg::ALPHA_RESET;
  endfunction

  task report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %0s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
  endtask

  function longint clamp31(input longint v);
    if (v > LIM31) return LIM31;
    if (v < -LIM31) return -LIM31;
    return v;
  endfunction

  function longint lim16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function gaze_vec_t unpack(input logic [31:0] f);
    gaze_vec_t r;
    r.x = longint'($signed(f[31:16])) * 16;
    r.y = longint'($signed(f[15:0])) * 16;
    return r;
  endfunction

  function gaze_vec_t vdiff(input gaze_vec_t a, input gaze_vec_t b);
    gaze_vec_t r;
    r.x = clamp31(a.x - b.x);
    r.y = clamp31(a.y - b.y);
    return r;
  endfunction

  function longint wedge(input gaze_vec_t a, input gaze_vec_t b);
    return a.x * b.y - a.y * b.x;
  endfunction

  function longint qdiv(input longint n, input longint d, input int fb);
    longint unsigned un, ud, q, r;
    bit neg;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = un / ud;
    r = un % ud;
    neg = (n < 0) != (d < 0);
    if (q > (unsigned'(LIM31) >> fb)) begin
      q = LIM31;
    end else begin
      for (int i = 0; i < fb; i++) begin
        q = q << 1;
        r = r << 1;
        if (r >= ud) begin
          r = r - ud;
          q = q | 1;
        end
      end
      if (q > unsigned'(LIM31)) q = LIM31;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function gaze_vec_t meet(input gaze_vec_t p1, input gaze_vec_t p2,
                           input gaze_vec_t q1, input gaze_vec_t q2);
    gaze_vec_t r;
    longint den, t1, t2;
    den = wedge(p2, q2);
    r.x = 0;
    r.y = 0;
    if (den == 0) begin
      flawed = 1;
      return r;
    end
    t1 = qdiv(wedge(q1, q2), den, 8);
    t2 = qdiv(wedge(p1, p2), den, 8);
    r.x = clamp31((p2.x * t1 - q2.x * t2) / 256);
    r.y = clamp31((p2.y * t1 - q2.y * t2) / 256);
    return r;
  endfunction

  function longint cross_ratio(input longint a, input longint b, input longint c,
                               input longint d);
    longint r1, r2;
    if (c == 0 || d == 0) begin
      flawed = 1;
      return 0;
    end
    r1 = qdiv(a, c, 16);
    r2 = qdiv(b, d, 16);
    return clamp31((r1 * r2) / 65536);
  endfunction

  function void note_observation(input logic [31:0] p, g, tl, tr, bl, br, input logic f);
    gaze_vec_t pu, gl, dl, vv, vh, e, u1, u2, u3, u4;
    gaze_vec_t c[4], t[4];
    longint mx, my, crx, cry, dx, dy;
    screen_pt_t s;
    flawed = 0;
    pu = unpack(p);
    gl = unpack(g);
    c[0] = unpack(tl);
    c[1] = unpack(tr);
    c[2] = unpack(bl);
    if (f) begin
      c[3] = unpack(br);
    end else begin
      mx = (c[0].x + c[1].x + c[2].x) / 3;
      my = (c[0].y + c[1].y + c[2].y) / 3;
      c[3].x = clamp31(mx + ((mx - c[0].x) * 41) / 40);
      c[3].y = clamp31(my + ((my - c[0].y) * 41) / 40);
    end
    for (int i = 0; i < 4; i++) begin
      dl = vdiff(c[i], gl);
      t[i].x = clamp31(gl.x + (dl.x * longint'(alpha[i])) / 4096);
      t[i].y = clamp31(gl.y + (dl.y * longint'(alpha[i])) / 4096);
    end
    vv = meet(t[0], vdiff(t[2], t[0]), t[1], vdiff(t[3], t[1]));
    vh = meet(t[0], vdiff(t[1], t[0]), t[2], vdiff(t[3], t[2]));
    e  = meet(t[0], vdiff(t[3], t[0]), t[1], vdiff(t[2], t[1]));
    u1 = meet(vv, vdiff(vv, e), t[0], vdiff(t[1], t[0]));
    u2 = meet(vv, vdiff(vv, pu), t[0], vdiff(t[1], t[0]));
    u3 = meet(vh, vdiff(vh, pu), t[0], vdiff(t[2], t[0]));
    u4 = meet(vh, vdiff(vh, e), t[0], vdiff(t[2], t[0]));
    crx = cross_ratio(wedge(t[1], u1), wedge(u2, t[0]), wedge(t[1], u2), wedge(u1, t[0]));
    cry = cross_ratio(wedge(t[0], u3), wedge(u4, t[2]), wedge(t[0], u4), wedge(u3, t[2]));
    dx = 65536 + crx;
    dy = 65536 + cry;
    if (dx == 0 || dy == 0) flawed = 1;
    s.sx = 0;
    s.sy = 0;
    if (!flawed) begin
      s.sx = 16'(lim16(16384 - qdiv(crx, dx, 14)));
      s.sy = 16'(lim16(qdiv(cry, dy, 14)));
    end
    s.degen = flawed;
    pending = {pending, s};
  endfunction

  task check_point(input logic signed [15:0] sx, sy, input logic dg);
    screen_pt_t w;
    if (pending.size() == 0) begin
      errors++;
      $display("unexpected screen point (%0d, %0d) at t=%0t", sx, sy, $realtime);
      return;
    end
    w = pending.pop_front();
    points++;
    if (w.degen) degens++;
    if (sx !== w.sx) report("screen_x", sx, w.sx);
    if (sy !== w.sy) report("screen_y", sy, w.sy);
    if (dg !== w.degen) report("degenerate", dg, w.degen);
  endtask
endclass

module cross_ratio_gaze_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [crgm_pkg::IDX_W-1:0] REG_UNUSED = 8'd7;
  localparam int LATENCY = 160;
  localparam int QUIET_LIMIT = 5000;
  localparam int PRESSURE_HOLD = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [crgm_pkg::IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] pupil_point = '0;
  logic [31:0] glint_point = '0;
  logic [31:0] top_left_point = '0;
  logic [31:0] top_right_point = '0;
  logic [31:0] bottom_left_point = '0;
  logic [31:0] bottom_right_point = '0;
  logic bottom_right_found = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;
  logic degenerate;

  gaze_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit pressure_go = 1'b0;
  int stall_cnt = 0;
  int quiet = 0;
  int sent = 0;

  cross_ratio_gaze_mapper dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
      out_stall <= 1'b1;
    end else if (pressure_go) begin
      pressure_go = 1'b0;
      stall_cnt <= PRESSURE_HOLD - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_cnt <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_point(screen_x, screen_y, degenerate);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet > QUIET_LIMIT) begin
        $display("timeout with %0d points outstanding", sb.pending.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pk(input int x, input int y);
    return {x[15:0], y[15:0]};
  endfunction

  task automatic send_obs(input logic [31:0] p, g, tl, tr, bl, br, input logic f);
    bit go;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pupil_point <= p;
    glint_point <= g;
    top_left_point <= tl;
    top_right_point <= tr;
    bottom_left_point <= bl;
    bottom_right_point <= br;
    bottom_right_found <= f;
    do begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end while (!go);
    sb.note_observation(p, g, tl, tr, bl, br, f);
    sent++;
  endtask

  task automatic write_alpha(input logic [crgm_pkg::IDX_W-1:0] idx, input logic [15:0] v);
    bit rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    if (idx < 4) sb.alpha[idx] = v;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // a quadrilateral of glints around the main glint, pupil somewhere near it
  task automatic send_scene();
    int cx, cy, w, h, j, px, py, bx, by;
    logic [31:0] br;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 1500) : $urandom_range(3, 120);
    h = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 1500) : $urandom_range(3, 120);
    w = w * 16;
    h = h * 16;
    j = $urandom_range(0, 3) * 16 + 15;
    cx = $signed($urandom_range(0, 16000)) - 8000;
    cy = $signed($urandom_range(0, 16000)) - 8000;
    px = cx + $signed($urandom_range(0, 2 * w)) - w;
    py = cy + $signed($urandom_range(0, 2 * h)) - h;
    bx = cx + w + $signed($urandom_range(0, 2 * j)) - j;
    by = cy + h + $signed($urandom_range(0, 2 * j)) - j;
    br = ($urandom_range(0, 1)) ? pk(bx, by) : $urandom();
    send_obs(pk(px, py),
             pk(cx + $signed($urandom_range(0, 2 * j)) - j, cy),
             pk(cx - w + $signed($urandom_range(0, j)), cy - h + $signed($urandom_range(0, j))),
             pk(cx + w - $signed($urandom_range(0, j)), cy - h + $signed($urandom_range(0, j))),
             pk(cx - w + $signed($urandom_range(0, j)), cy + h - $signed($urandom_range(0, j))),
             br, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_directed();
    logic [31:0] tl, tr, bl, br;
    tl = pk(-800, -600);
    tr = pk(800, -600);
    bl = pk(-800, 600);
    br = pk(800, 600);
    send_obs(pk(0, 0), pk(0, 0), tl, tr, bl, br, 1'b1);
    send_obs(pk(0, 0), pk(0, 0), tl, tr, bl, 32'hdead_beef, 1'b0);
    send_obs(pk(300, -200), pk(16, 8), tl, tr, bl, br, 1'b1);
    send_obs(pk(-800, -600), pk(0, 0), tl, tr, bl, br, 1'b0);
    send_obs(pk(800, 600), pk(0, 0), tl, tr, bl, br, 1'b1);
    send_obs(pk(5000, 4000), pk(0, 0), tl, tr, bl, br, 1'b1);
    send_obs(pk(-800, 0), pk(0, 0), tl, tr, bl, br, 1'b1);
    send_obs('0, '0, '0, '0, '0, '0, 1'b0);
    send_obs('0, '0, '0, '0, '0, '0, 1'b1);
    send_obs('1, '1, '1, '1, '1, '1, 1'b1);
    send_obs(32'h7fff_7fff, 32'h8000_8000, 32'h8000_8000, 32'h7fff_8000,
             32'h8000_7fff, 32'h7fff_7fff, 1'b1);
    send_obs(32'h8000_8000, 32'h7fff_7fff, 32'h8000_8000, 32'h7fff_8000,
             32'h8000_7fff, 32'h7fff_7fff, 1'b0);
    send_obs(pk(0, 0), pk(0, 0), pk(-10, 0), pk(0, 0), pk(10, 0), pk(20, 0), 1'b1);
    send_obs(pk(1, 1), pk(0, 0), tl, tl, bl, br, 1'b1);
    send_obs(pk(3, -7), pk(-30, 40), pk(-900, -500), pk(700, -650),
             pk(-750, 620), pk(820, 580), 1'b1);
    send_obs(32'h5555_aaaa, 32'haaaa_5555, 32'h0f0f_f0f0, 32'hf0f0_0f0f,
             32'h3333_cccc, 32'hcccc_3333, 1'b1);
  endtask

  task automatic run_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_obs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 1'($urandom_range(0, 1)));
      end else begin
        send_scene();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_alpha(crgm_pkg::REG_ALPHA_TL, 16'd8192);
    write_alpha(crgm_pkg::REG_ALPHA_TR, 16'd8192);
    write_alpha(crgm_pkg::REG_ALPHA_BL, 16'd8192);
    write_alpha(crgm_pkg::REG_ALPHA_BR, 16'd8192);
    write_alpha(REG_UNUSED, 16'hffff);
    send_directed();
    run_phase(170);
    drain();

    write_alpha(crgm_pkg::REG_ALPHA_TL, 16'd0);
    write_alpha(crgm_pkg::REG_ALPHA_TR, 16'd65535);
    write_alpha(crgm_pkg::REG_ALPHA_BL, 16'd65535);
    write_alpha(crgm_pkg::REG_ALPHA_BR, 16'd0);
    send_directed();
    run_phase(120);
    drain();

    write_alpha(crgm_pkg::REG_ALPHA_TL, 16'd4096);
    write_alpha(crgm_pkg::REG_ALPHA_TR, 16'd4096);
    write_alpha(crgm_pkg::REG_ALPHA_BL, 16'd4096);
    write_alpha(crgm_pkg::REG_ALPHA_BR, 16'd4096);
    run_phase(40);
    pressure_go = 1'b1;
    run_phase(160);
    drain();

    write_alpha(crgm_pkg::REG_ALPHA_TL, 16'd65535);
    write_alpha(crgm_pkg::REG_ALPHA_TR, 16'd65535);
    write_alpha(crgm_pkg::REG_ALPHA_BL, 16'd65535);
    write_alpha(crgm_pkg::REG_ALPHA_BR, 16'd65535);
    run_phase(80);
    drain();

    write_alpha(crgm_pkg::REG_ALPHA_TL, 16'($urandom_range(6000, 12000)));
    write_alpha(crgm_pkg::REG_ALPHA_TR, 16'($urandom_range(6000, 12000)));
    write_alpha(crgm_pkg::REG_ALPHA_BL, 16'($urandom_range(6000, 12000)));
    write_alpha(crgm_pkg::REG_ALPHA_BR, 16'($urandom()));
    run_phase(120);
    idle_on = 1'b0;
    run_phase(130);
    drain();

    $display("sent %0d observations over 5 alpha settings incl. extremes", sent);
    $display("checked %0d screen points, %0d degenerate", sb.points, sb.degens);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

FILE: files.f
src/crgm_pkg.sv
src/crgm_div.sv
src/cross_ratio_gaze_mapper.sv
verif/cross_ratio_gaze_mapper_tb.sv
